// ===== design/camera_distance_depth_sort_assert.svh =====
// Assertion macros used by the depth sort top module.
`ifndef CAMERA_DISTANCE_DEPTH_SORT_ASSERT_SVH
`define CAMERA_DISTANCE_DEPTH_SORT_ASSERT_SVH

// Same-cycle implication.
`define CDDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("depth sort assertion failed");

// Next-cycle implication.
`define CDDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("depth sort assertion failed");

`endif

// ===== design/cdds_pkg.sv =====
`default_nettype none
package cdds_pkg;

	localparam int COORD_W = 16;
	localparam int MAT_W   = 16;
	localparam int IDX_W   = 6;
	localparam int DIST_W  = 34;
	localparam int ABS_W   = 16;
	localparam int PROD_W  = 32;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		REG_CAMERA_X   = 2'd0,
		REG_CAMERA_Y   = 2'd1,
		REG_CAMERA_Z   = 2'd2,
		REG_SORT_DESC  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		coord_t            pos_x;
		coord_t            pos_y;
		coord_t            pos_z;
		logic [MAT_W-1:0]  material_id;
		logic              last_object;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]  object_index;
		logic [MAT_W-1:0]  out_material;
		logic [DIST_W-1:0] distance_squared;
		logic              overflowed;
		logic              last_result;
	} out_word_t;

	typedef struct packed {
		cfg_reg_t          index;
		logic [COORD_W-1:0] data;
	} cfg_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] sq_dist;
		logic [MAT_W-1:0]  mat;
	} entry_t;

endpackage
`default_nettype wire

// ===== design/cdds_stream_if.sv =====
`default_nettype none
interface cdds_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/camera_distance_depth_sort.sv =====
// Camera-distance depth sort.
// obj: one object word per accept (Q8.8 position, material id, last_object).
// cfg: register writes (camera_x/y/z, sort_descending), always ready; write
//   only while the block is idle.
// sorted: one word per stored object, emitted after the word marked last,
//   nearest first (farthest first when sort_descending is set), ties by lower
//   material id, then arrival order.
// For a stored object, one shared 16x16 squarer runs the three axes through
//   a diff / square / accumulate chain. obj.ready is low meanwhile.
// A word that arrives with MAX_OBJECTS already stored is dropped and flags
//   the list as overflowed.
// Output is a selection sort over the object memory, one read per cycle
//   while scanning: each result scans all n stored objects, drains, emits.
// An output register holds each result; a stall on sorted.ready holds the
//   word and the scan for the next result stops at its end until the slot
//   frees. After the final result the list is empty and obj.ready returns.
// Reset clears the control and camera registers, the list count and the
//   overflow flag; memory contents need no clearing.
`default_nettype none
`include "camera_distance_depth_sort_assert.svh"
module camera_distance_depth_sort #(
	parameter int MAX_OBJECTS = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	cdds_stream_if.sink    obj,
	cdds_stream_if.sink    cfg,
	cdds_stream_if.source  sorted
);
	import cdds_pkg::*;

	localparam int AW = $clog2(MAX_OBJECTS);
	localparam int CW = $clog2(MAX_OBJECTS + 1);

	state_t            state_q;
	state_t            state_d;

	in_word_t          in_q;
	coord_t            cam_x_q;
	coord_t            cam_y_q;
	coord_t            cam_z_q;
	logic              desc_q;

	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [CW-1:0]     emit_cnt_q;
	logic [MAX_OBJECTS-1:0] emitted_q;

	entry_t            mem [MAX_OBJECTS];
	logic [AW-1:0]     rd_addr_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_addr_s1;
	entry_t            rd_data_s1;

	logic              out_valid_q;
	out_word_t         out_q;

	logic              full;
	logic              in_fire;
	logic              cfg_fire;
	logic              last_rd;
	logic              slot_free;
	logic              emit_last;
	logic              emit_fire;
	logic              dist_start;
	logic              dist_done;
	logic [DIST_W-1:0] sq_dist;
	logic              scan_issue;
	logic              sel_clr;
	logic              cand_vld;
	entry_t            best;
	logic [IDX_W-1:0]  best_idx;

	assign full      = count_q == CW'(MAX_OBJECTS);
	assign in_fire   = obj.valid && obj.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign last_rd   = rd_addr_q == AW'(count_q - CW'(1));
	assign slot_free = !out_valid_q || sorted.ready;
	assign emit_last = emit_cnt_q == count_q - CW'(1);
	assign cand_vld  = rd_vld_s1 && !emitted_q[rd_addr_s1];

	cdds_dist_unit u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dist_start),
		.pos_x   (in_q.pos_x),
		.pos_y   (in_q.pos_y),
		.pos_z   (in_q.pos_z),
		.cam_x   (cam_x_q),
		.cam_y   (cam_y_q),
		.cam_z   (cam_z_q),
		.done    (dist_done),
		.sq_dist (sq_dist)
	);

	cdds_select u_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (sel_clr),
		.cand_vld (cand_vld),
		.cand     (rd_data_s1),
		.cand_idx (IDX_W'(rd_addr_s1)),
		.desc     (desc_q),
		.best     (best),
		.best_idx (best_idx)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (!full)
						state_d = ST_DIST;
					else if (obj.payload.last_object)
						state_d = ST_SCAN;
				end
			end
			ST_DIST: begin
				if (dist_done)
					state_d = in_q.last_object ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (last_rd)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free)
					state_d = emit_last ? ST_IDLE : ST_SCAN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		obj.ready  = state_q == ST_IDLE;
		dist_start = state_q == ST_IDLE && obj.valid && !full;
		scan_issue = state_q == ST_SCAN;
		emit_fire  = state_q == ST_EMIT && slot_free;
		sel_clr    = emit_fire || state_q == ST_IDLE;
	end

	assign cfg.ready      = 1'b1;
	assign sorted.valid   = out_valid_q;
	assign sorted.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cam_x_q     <= '0;
			cam_y_q     <= '0;
			cam_z_q     <= '0;
			desc_q      <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			emit_cnt_q  <= '0;
			emitted_q   <= '0;
			rd_addr_q   <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;

			if (cfg_fire) begin
				case (cfg.payload.index)
					REG_CAMERA_X:  cam_x_q <= cfg.payload.data;
					REG_CAMERA_Y:  cam_y_q <= cfg.payload.data;
					REG_CAMERA_Z:  cam_z_q <= cfg.payload.data;
					REG_SORT_DESC: desc_q  <= cfg.payload.data[0];
					default: begin
					end
				endcase
			end

			if (in_fire && full)
				ovf_q <= 1'b1;
			if (dist_done)
				count_q <= count_q + CW'(1);

			if (scan_issue)
				rd_addr_q <= rd_addr_q + AW'(1);
			else
				rd_addr_q <= '0;

			if (state_q == ST_IDLE) begin
				emitted_q  <= '0;
				emit_cnt_q <= '0;
			end

			if (emit_fire) begin
				out_valid_q                 <= 1'b1;
				emitted_q[best_idx[AW-1:0]] <= 1'b1;
				emit_cnt_q                  <= emit_cnt_q + CW'(1);
				if (emit_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end else if (sorted.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			in_q <= obj.payload;
		if (dist_done)
			mem[count_q[AW-1:0]] <= '{sq_dist: sq_dist, mat: in_q.material_id};
		rd_data_s1 <= mem[rd_addr_q];
		rd_addr_s1 <= rd_addr_q;
		if (emit_fire) begin
			out_q.object_index     <= best_idx;
			out_q.out_material     <= best.mat;
			out_q.distance_squared <= best.sq_dist;
			out_q.overflowed       <= ovf_q;
			out_q.last_result      <= emit_last;
		end
	end

	`CDDS_ASSERT_IMPL(a_count_cap, clk, arst_n, 1'b1, count_q <= CW'(MAX_OBJECTS))
	`CDDS_ASSERT_IMPL(a_done_in_dist, clk, arst_n, dist_done, state_q == ST_DIST)
	`CDDS_ASSERT_IMPL(a_emit_fresh, clk, arst_n, emit_fire, !emitted_q[best_idx[AW-1:0]])
	`CDDS_ASSERT_NEXT(a_list_cleared, clk, arst_n, emit_fire && emit_last, count_q == '0 && !ovf_q)
	`CDDS_ASSERT_NEXT(a_busy_after_load, clk, arst_n, in_fire && !full, !obj.ready)

endmodule
`default_nettype wire

// ===== design/cdds_dist_unit.sv =====
`default_nettype none
module cdds_dist_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire cdds_pkg::coord_t           pos_x,
	input  wire cdds_pkg::coord_t           pos_y,
	input  wire cdds_pkg::coord_t           pos_z,
	input  wire cdds_pkg::coord_t           cam_x,
	input  wire cdds_pkg::coord_t           cam_y,
	input  wire cdds_pkg::coord_t           cam_z,
	output logic                            done,
	output logic [cdds_pkg::DIST_W-1:0]     sq_dist
);
	import cdds_pkg::*;

	localparam logic [2:0] LAST_AXIS = 3'd2;
	localparam logic [2:0] LAST_STEP = 3'd4;

	logic [2:0]               cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [ABS_W-1:0]         absd_s1;
	logic [PROD_W-1:0]        prod_s2;
	logic [DIST_W-1:0]        acc_q;

	coord_t                   op_a;
	coord_t                   op_b;
	logic signed [COORD_W:0]  diff;
	logic signed [COORD_W:0]  ndiff;
	logic [ABS_W-1:0]         absd;

	always_comb begin
		case (cnt_q)
			3'd0: begin
				op_a = pos_x;
				op_b = cam_x;
			end
			3'd1: begin
				op_a = pos_y;
				op_b = cam_y;
			end
			default: begin
				op_a = pos_z;
				op_b = cam_z;
			end
		endcase
		diff  = {op_a[COORD_W-1], op_a} - {op_b[COORD_W-1], op_b};
		ndiff = -diff;
		absd  = diff[COORD_W] ? ndiff[ABS_W-1:0] : diff[ABS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// three-deep chain: abs diff, square, accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q <= LAST_AXIS)
				absd_s1 <= absd;
			if (cnt_q >= 3'd1 && cnt_q <= LAST_AXIS + 3'd1)
				prod_s2 <= absd_s1 * absd_s1;
			if (cnt_q >= 3'd2)
				acc_q <= acc_q + DIST_W'(prod_s2);
		end
	end

	assign done    = done_q;
	assign sq_dist = acc_q;

endmodule
`default_nettype wire

// ===== design/cdds_select.sv =====
`default_nettype none
module cdds_select (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      clr,
	input  wire logic                      cand_vld,
	input  wire cdds_pkg::entry_t          cand,
	input  wire logic [cdds_pkg::IDX_W-1:0] cand_idx,
	input  wire logic                      desc,
	output cdds_pkg::entry_t               best,
	output logic [cdds_pkg::IDX_W-1:0]     best_idx
);
	import cdds_pkg::*;

	logic             best_vld_q;
	entry_t           best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             take;

	// equal keys keep the earlier one, scan runs in arrival order
	function automatic logic precedes(entry_t a, entry_t b, logic d);
		logic r;
		if (a.sq_dist != b.sq_dist)
			r = d ? (a.sq_dist > b.sq_dist) : (a.sq_dist < b.sq_dist);
		else
			r = a.mat < b.mat;
		return r;
	endfunction

	assign take = cand_vld && (!best_vld_q || precedes(cand, best_q, desc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
		end else if (clr) begin
			best_vld_q <= 1'b0;
		end else if (take) begin
			best_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !clr) begin
			best_q     <= cand;
			best_idx_q <= cand_idx;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule
`default_nettype wire
